// File: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared constants, payload structs, command and status codes, and the
// control types passed between the queue control and its level table.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int CAPACITY_DEF     = 64;
	localparam int PAYLOAD_BITS_DEF = 16;
	localparam int SEV_W            = 3;
	localparam int ID_W             = 16;
	localparam int OCC_W            = 7;
	localparam int NUM_LVL          = 1 << SEV_W;

	typedef logic [SEV_W-1:0] sev_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_REMOVE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		cmd_t            cmd;
		sev_t            severity;
		logic [ID_W-1:0] patient_id;
	} cmd_item_t;

	typedef struct packed {
		status_t          status;
		sev_t             out_severity;
		logic [ID_W-1:0]  out_patient_id;
		logic [OCC_W-1:0] occupancy;
	} rsp_item_t;

	// Update request for one level of the level table.
	typedef struct packed {
		logic wr_head;
		logic wr_tail;
		logic set_valid;
		logic clr_valid;
	} lvl_upd_t;

endpackage

// File: hw/rtl/spq_ram.sv
// ----------------------------------------------------------------------------
// Stable priority queue storage RAM
// Simple dual-port synchronous RAM, one write port and one read port, with
// registered read data that holds its value while no read is issued.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/spq_lvl.sv
// ----------------------------------------------------------------------------
// Stable priority queue level table
// Head and tail pointers of the linked list kept for each severity level,
// the level occupied flags, and the search for the highest occupied level.
// ----------------------------------------------------------------------------
module spq_lvl #(
	parameter int PTR_W = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spq_pkg::sev_t     idx,
	input  spq_pkg::lvl_upd_t upd,
	input  logic [PTR_W-1:0]  new_head,
	input  logic [PTR_W-1:0]  new_tail,
	output logic [PTR_W-1:0]  head_ptr,
	output logic [PTR_W-1:0]  tail_ptr,
	output logic              lvl_valid,
	output spq_pkg::sev_t     top_lvl,
	output logic              any_valid
);

	import spq_pkg::*;

	logic [PTR_W-1:0]   head_q [NUM_LVL];
	logic [PTR_W-1:0]   tail_q [NUM_LVL];
	logic [NUM_LVL-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (upd.wr_head) begin
			head_q[idx] <= new_head;
		end
		if (upd.wr_tail) begin
			tail_q[idx] <= new_tail;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (upd.set_valid) begin
			valid_q[idx] <= 1'b1;
		end else if (upd.clr_valid) begin
			valid_q[idx] <= 1'b0;
		end
	end

	assign head_ptr  = head_q[idx];
	assign tail_ptr  = tail_q[idx];
	assign lvl_valid = valid_q[idx];
	assign any_valid = |valid_q;

	// The highest occupied level wins.
	always_comb begin
		top_lvl = '0;
		for (int i = 0; i < NUM_LVL; i++) begin
			if (valid_q[i]) begin
				top_lvl = SEV_W'(i);
			end
		end
	end

endmodule

// File: hw/rtl/stable_priority_queue_top.sv
// ----------------------------------------------------------------------------
// Stable priority queue
// Priority queue with first-in first-out order among items of equal severity,
// built as one linked list per severity level over a shared node memory.
// ----------------------------------------------------------------------------
// Usage notes.
// Commands enter on the cmd channel (cmd_valid, cmd_ready, cmd_item). An
// insert stores the severity and payload behind every waiting item of equal
// or higher severity; a remove returns the oldest item of the highest
// severity. Each command produces exactly one item on the rsp channel
// (rsp_valid, rsp_ready, rsp_item) carrying status, the removed item and the
// occupancy after the command. An insert into a full queue is refused with a
// full status, and a remove from an empty queue returns an empty status.
// A command is handled in a read step, which issues the reads of the node
// and link memories, and a write-back step, which writes back the links and
// registers the response. The read data of the memories is registered and
// the successor link must come back before the level table can be updated,
// so the block takes no new command until the last one is written back. The
// response is registered in the write-back step.
// A finished response waits in the output register while the next command
// is already accepted; if the receiver keeps rsp_ready low, that command
// holds in its write-back step until the register frees up.
// Reset empties the queue at once; no clearing pass is needed because free
// nodes come from a bump counter and a free list threaded through the links.
// ----------------------------------------------------------------------------
module stable_priority_queue_top #(
	parameter int CAPACITY     = spq_pkg::CAPACITY_DEF,
	parameter int PAYLOAD_BITS = spq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  spq_pkg::cmd_item_t cmd_item,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output spq_pkg::rsp_item_t rsp_item
);

	import spq_pkg::*;

	localparam int PTR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t state_q, state_nx;

	// Occupancy, nodes ever handed out, and the head of the free list.
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] bump_q;
	logic [PTR_W-1:0] free_head_q;

	// Command held between its read cycle and its write-back cycle.
	cmd_t             cmd_s1;
	sev_t             lvl_s1;
	status_t          stat_s1;
	logic [PTR_W-1:0] new_ptr_s1;
	logic             from_free_s1;

	rsp_item_t rsp_item_q;
	logic      rsp_valid_q;

	logic accept, commit;
	logic is_full, is_empty, free_avail;
	logic ins_ok, rem_ok;
	logic ins_commit, rem_commit;
	logic [PTR_W-1:0] alloc_ptr;
	status_t          stat_in;

	sev_t             lvl_idx;
	lvl_upd_t         lvl_upd;
	logic [PTR_W-1:0] head_ptr, tail_ptr, lvl_new_head;
	logic             lvl_valid, any_valid;
	sev_t             top_lvl;

	logic [PAYLOAD_BITS-1:0] pay_wdata, pay_rdata;
	logic [PAYLOAD_BITS+ID_W-1:0] pay_in_ext, pay_out_ext;
	logic             nxt_we, nxt_re;
	logic [PTR_W-1:0] nxt_waddr, nxt_raddr, nxt_wdata, nxt_rdata;

	logic [CNT_W-1:0]       count_nx;
	logic [CNT_W+OCC_W-1:0] occ_ext;

	assign is_full    = (count_q == CNT_W'(CAPACITY));
	assign is_empty   = (count_q == '0);
	// Nodes handed out but not occupied sit on the free list.
	assign free_avail = (bump_q != count_q);
	assign alloc_ptr  = free_avail ? free_head_q : bump_q[PTR_W-1:0];

	assign accept = cmd_valid && cmd_ready;
	assign ins_ok = accept && (cmd_item.cmd == CMD_INSERT) && !is_full;
	assign rem_ok = accept && (cmd_item.cmd == CMD_REMOVE) && !is_empty;

	always_comb begin
		stat_in = STAT_OK;
		if (cmd_item.cmd == CMD_INSERT && is_full) begin
			stat_in = STAT_FULL;
		end else if (cmd_item.cmd == CMD_REMOVE && is_empty) begin
			stat_in = STAT_EMPTY;
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_nx = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		cmd_ready = 1'b0;
		commit    = 1'b0;
		case (state_q)
			S_IDLE:  cmd_ready = 1'b1;
			S_EXEC:  commit    = !rsp_valid_q || rsp_ready;
			default: begin
				cmd_ready = 1'b0;
				commit    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign ins_commit = commit && (cmd_s1 == CMD_INSERT) && (stat_s1 == STAT_OK);
	assign rem_commit = commit && (cmd_s1 == CMD_REMOVE) && (stat_s1 == STAT_OK);

	// The level table is looked up at the highest occupied level while idle,
	// and at the level of the command in flight during write-back.
	assign lvl_idx = (state_q == S_IDLE) ? top_lvl : lvl_s1;

	always_comb begin
		lvl_upd = '0;
		if (ins_commit) begin
			lvl_upd.wr_tail = 1'b1;
			if (!lvl_valid) begin
				lvl_upd.wr_head   = 1'b1;
				lvl_upd.set_valid = 1'b1;
			end
		end else if (rem_commit) begin
			if (head_ptr == tail_ptr) begin
				lvl_upd.clr_valid = 1'b1;
			end else begin
				lvl_upd.wr_head = 1'b1;
			end
		end
	end

	assign lvl_new_head = (cmd_s1 == CMD_INSERT) ? new_ptr_s1 : nxt_rdata;

	spq_lvl #(
		.PTR_W(PTR_W)
	) u_lvl (
		.clk      (clk),
		.arst_n   (arst_n),
		.idx      (lvl_idx),
		.upd      (lvl_upd),
		.new_head (lvl_new_head),
		.new_tail (new_ptr_s1),
		.head_ptr (head_ptr),
		.tail_ptr (tail_ptr),
		.lvl_valid(lvl_valid),
		.top_lvl  (top_lvl),
		.any_valid(any_valid)
	);

	// Payload is written at allocation and read at the head on a remove.
	assign pay_in_ext = {{PAYLOAD_BITS{1'b0}}, cmd_item.patient_id};
	assign pay_wdata  = pay_in_ext[PAYLOAD_BITS-1:0];

	spq_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(PAYLOAD_BITS)
	) u_pay_ram (
		.clk  (clk),
		.we   (ins_ok),
		.waddr(alloc_ptr),
		.wdata(pay_wdata),
		.re   (rem_ok),
		.raddr(head_ptr),
		.rdata(pay_rdata)
	);

	// Link memory: the next node in a level list, or in the free list.
	// The read side fetches the successor of the node being taken off a
	// list; the write side links a new tail or pushes a freed node.
	assign nxt_re    = (ins_ok && free_avail) || rem_ok;
	assign nxt_raddr = rem_ok ? head_ptr : free_head_q;
	assign nxt_we    = (ins_commit && lvl_valid) || rem_commit;
	assign nxt_waddr = (cmd_s1 == CMD_INSERT) ? tail_ptr : head_ptr;
	assign nxt_wdata = (cmd_s1 == CMD_INSERT) ? new_ptr_s1 : free_head_q;

	spq_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(PTR_W)
	) u_nxt_ram (
		.clk  (clk),
		.we   (nxt_we),
		.waddr(nxt_waddr),
		.wdata(nxt_wdata),
		.re   (nxt_re),
		.raddr(nxt_raddr),
		.rdata(nxt_rdata)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1       <= cmd_item.cmd;
			lvl_s1       <= (cmd_item.cmd == CMD_REMOVE) ? top_lvl : cmd_item.severity;
			stat_s1      <= stat_in;
			new_ptr_s1   <= alloc_ptr;
			from_free_s1 <= free_avail;
		end
	end

	always_comb begin
		count_nx = count_q;
		if (ins_commit) begin
			count_nx = count_q + CNT_W'(1);
		end else if (rem_commit) begin
			count_nx = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bump_q  <= '0;
		end else begin
			count_q <= count_nx;
			if (ins_ok && !free_avail) begin
				bump_q <= bump_q + CNT_W'(1);
			end
		end
	end

	// The free list head is only meaningful while nodes are on it, so it
	// needs no reset.
	always_ff @(posedge clk) begin
		if (ins_commit && from_free_s1) begin
			free_head_q <= nxt_rdata;
		end else if (rem_commit) begin
			free_head_q <= head_ptr;
		end
	end

	assign pay_out_ext = {{ID_W{1'b0}}, pay_rdata};
	assign occ_ext     = {{OCC_W{1'b0}}, count_nx};

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_item_q.status         <= stat_s1;
			rsp_item_q.out_severity   <= rem_commit ? lvl_s1 : '0;
			rsp_item_q.out_patient_id <= rem_commit ? pay_out_ext[ID_W-1:0] : '0;
			rsp_item_q.occupancy      <= occ_ext[OCC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

	// The occupancy never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("occupancy exceeds capacity");

	// Every occupied node was handed out by the bump counter.
	a_bump_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q >= count_q)
		else $error("more items stored than nodes allocated");

	// The level flags agree with the occupancy.
	a_levels_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == !any_valid)
		else $error("level flags disagree with occupancy");

	// A successful remove lowers the occupancy by one.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		rem_commit |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("remove did not lower occupancy");

endmodule
